// ===== sv/assert_macros.svh =====
// Assertion macros shared by the speed set-point limiter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== sv/vssl_pkg.sv =====
// Types and constants shared by the speed set-point limiter modules.
`timescale 1ns / 1ps

package vssl_pkg;

   localparam int SPEED_W    = 13;
   localparam int PROB_W     = 13;
   localparam int ANGLE_W    = 12;
   localparam int ACTION_W   = 3;
   localparam int COUNT_W    = 8;
   localparam int BRAKE_W    = 11;
   localparam int SLEW_W     = 16;
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 40;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [PROB_W-1:0] Q12_ONE = 13'd4096;

   localparam logic [ACTION_W-1:0] ACT_OTHER         = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_SLOW_RIGHT    = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_SLOW_LEFT     = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_NORMAL_RIGHT  = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_NORMAL_LEFT   = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_PARK_DETECT   = 3'd5;

   localparam logic [1:0] REG_MIN_SPEED       = 2'd0;
   localparam logic [1:0] REG_CURVE_SPEED     = 2'd1;
   localparam logic [1:0] REG_DETECTION_SPEED = 2'd2;

   localparam logic [SPEED_W-1:0] MIN_SPEED_RESET       = 13'd512;
   localparam logic [SPEED_W-1:0] CURVE_SPEED_RESET     = 13'd1024;
   localparam logic [SPEED_W-1:0] DETECTION_SPEED_RESET = 13'd768;

   typedef struct packed {
      logic [SPEED_W-1:0] min_speed;
      logic [SPEED_W-1:0] curve_speed;
      logic [SPEED_W-1:0] detection_speed;
   } csr_type;

   typedef struct packed {
      logic [PROB_W-1:0]  p;
      logic [PROB_W-1:0]  c;
      logic [ANGLE_W-1:0] a;
      logic [SPEED_W-1:0] mn_b;
      logic [SPEED_W-1:0] mx_b;
      logic [PROB_W-1:0]  mx_w;
      logic               mx_same;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_write_type;

   typedef struct packed {
      logic    full;
      logic    empty;
      cmd_type head;
   } queue_status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MN,
      ST_MX,
      ST_TS,
      ST_TD,
      ST_DR,
      ST_NUM,
      ST_QT,
      ST_TGT,
      ST_BR,
      ST_FIN
   } back_state_type;

endpackage

// ===== sv/vssl_front.sv =====
// Front end: accepts request transactions, tracks the detection countdown, selects blend operands.
`timescale 1ns / 1ps

module vssl_front (
   input  logic                              clock,
   input  logic                              reset,
   input  vssl_pkg::csr_type                 csr,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // Fields from bit 0 up: lane_probability, sign_absent, steer_angle, straight_slow,
   // straight_normal, curve_likelihood, countdown_load, countdown_value, zero fill.
   input  logic [vssl_pkg::REQ_DATA_W-1:0]   req_tdata,
   // Fields from bit 0 up: action.
   input  logic [vssl_pkg::ACTION_W-1:0]     req_tuser,
   input  logic                              queue_full,
   output vssl_pkg::queue_write_type         queue_write,
   output logic [vssl_pkg::COUNT_W-1:0]      countdown
);

   logic                              accept;
   logic [vssl_pkg::PROB_W-1:0]       p_raw;
   logic [vssl_pkg::PROB_W-1:0]       c_raw;
   logic [vssl_pkg::PROB_W-1:0]       p_clamped;
   logic [vssl_pkg::PROB_W-1:0]       c_clamped;
   logic                              sign_absent;
   logic [vssl_pkg::ANGLE_W-1:0]      steer_angle;
   logic [vssl_pkg::ANGLE_W-1:0]      angle_abs;
   logic [vssl_pkg::SPEED_W-1:0]      straight_slow;
   logic [vssl_pkg::SPEED_W-1:0]      straight_normal;
   logic                              countdown_load;
   logic [vssl_pkg::COUNT_W-1:0]      countdown_value;
   logic [vssl_pkg::COUNT_W-1:0]      countdown_eff;
   logic [vssl_pkg::COUNT_W-1:0]      countdown_ff;
   logic [vssl_pkg::COUNT_W-1:0]      countdown_in;
   logic [vssl_pkg::SPEED_W-1:0]      det_min;
   logic                              detect_mode;
   vssl_pkg::cmd_type                 cmd;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;

   assign p_raw           = req_tdata[12:0];
   assign sign_absent     = req_tdata[13];
   assign steer_angle     = req_tdata[25:14];
   assign straight_slow   = req_tdata[38:26];
   assign straight_normal = req_tdata[51:39];
   assign c_raw           = req_tdata[64:52];
   assign countdown_load  = req_tdata[65];
   assign countdown_value = req_tdata[73:66];

   assign p_clamped = (p_raw > vssl_pkg::Q12_ONE) ? vssl_pkg::Q12_ONE : p_raw;
   assign c_clamped = (c_raw > vssl_pkg::Q12_ONE) ? vssl_pkg::Q12_ONE : c_raw;
   assign angle_abs = steer_angle[vssl_pkg::ANGLE_W-1] ? (~steer_angle + 12'd1) : steer_angle;

   assign countdown_eff = countdown_load ? countdown_value : countdown_ff;
   assign det_min = (csr.curve_speed < csr.detection_speed) ? csr.curve_speed
                                                            : csr.detection_speed;
   assign detect_mode = (countdown_eff != '0)
                        || (sign_absent && (req_tuser == vssl_pkg::ACT_PARK_DETECT));

   always_comb begin
      cmd.p       = p_clamped;
      cmd.c       = c_clamped;
      cmd.a       = angle_abs;
      cmd.mn_b    = csr.curve_speed;
      cmd.mx_b    = csr.curve_speed;
      cmd.mx_w    = p_clamped;
      cmd.mx_same = 1'b1;
      if (detect_mode) begin
         cmd.mn_b    = det_min;
         cmd.mx_b    = csr.detection_speed;
         cmd.mx_same = 1'b0;
      end else if (sign_absent) begin
         unique case (req_tuser) inside
            vssl_pkg::ACT_SLOW_RIGHT, vssl_pkg::ACT_SLOW_LEFT: begin
               cmd.mx_b    = straight_slow;
               cmd.mx_same = 1'b0;
            end
            vssl_pkg::ACT_NORMAL_RIGHT, vssl_pkg::ACT_NORMAL_LEFT: begin
               cmd.mx_b    = straight_normal;
               cmd.mx_same = 1'b0;
            end
            default: begin
               cmd.mx_same = 1'b1;
            end
         endcase
         if ((req_tuser == vssl_pkg::ACT_SLOW_LEFT) || (req_tuser == vssl_pkg::ACT_NORMAL_LEFT)) begin
            cmd.mx_w = p_clamped >> 1;
         end
      end
   end

   always_comb begin
      countdown_in = countdown_ff;
      if (accept) begin
         countdown_in = (countdown_eff != '0) ? (countdown_eff - 8'd1) : countdown_eff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         countdown_ff <= '0;
      end else begin
         countdown_ff <= countdown_in;
      end
   end

   assign queue_write.valid = accept;
   assign queue_write.cmd   = cmd;
   assign countdown         = countdown_ff;

endmodule

// ===== sv/vssl_queue.sv =====
// Two-entry command queue between the front end and the back end.
`timescale 1ns / 1ps

module vssl_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  vssl_pkg::queue_write_type  queue_write,
   input  logic                       pop,
   output vssl_pkg::queue_status_type status
);

   vssl_pkg::cmd_type                     entry_ff [vssl_pkg::QUEUE_DEPTH];
   logic [vssl_pkg::QUEUE_PTR_W-1:0]      wr_ptr_ff;
   logic [vssl_pkg::QUEUE_PTR_W-1:0]      wr_ptr_in;
   logic [vssl_pkg::QUEUE_PTR_W-1:0]      rd_ptr_ff;
   logic [vssl_pkg::QUEUE_PTR_W-1:0]      rd_ptr_in;
   logic [vssl_pkg::QUEUE_CNT_W-1:0]      count_ff;
   logic [vssl_pkg::QUEUE_CNT_W-1:0]      count_in;
   logic                                  push;

   assign push = queue_write.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == vssl_pkg::QUEUE_PTR_W'(vssl_pkg::QUEUE_DEPTH - 1))
                     ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == vssl_pkg::QUEUE_PTR_W'(vssl_pkg::QUEUE_DEPTH - 1))
                     ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= queue_write.cmd;
      end
   end

   assign status.full  = (count_ff == vssl_pkg::QUEUE_CNT_W'(vssl_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign status.head  = entry_ff[rd_ptr_ff];

endmodule

// ===== sv/vssl_back.sv =====
// Back end: sequencer around one shared multiplier computing target, brake and slewed speed.
`timescale 1ns / 1ps

module vssl_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [vssl_pkg::SPEED_W-1:0]      min_speed,
   input  vssl_pkg::queue_status_type        queue_status,
   output logic                              pop,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // Fields from bit 0 up: set_speed, brake_amount, slewed_speed.
   output logic [vssl_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   localparam int MUL_W  = 22;
   localparam int PROD_W = 2 * MUL_W;
   localparam logic [vssl_pkg::ANGLE_W-1:0] STRAIGHT_ZONE = 12'd160;
   localparam logic [16:0] RECIP_5  = 17'd52429;
   localparam logic [20:0] RECIP_15 = 21'd1118482;
   localparam logic signed [16:0] STEP_UP   = 17'sd102;
   localparam logic signed [16:0] STEP_DOWN = -17'sd307;
   localparam logic signed [17:0] SAT_HI = 18'sd32767;
   localparam logic signed [17:0] SAT_LO = -18'sd32768;
   localparam logic [vssl_pkg::BRAKE_W-1:0] BRAKE_MAX = 11'd1024;

   vssl_pkg::back_state_type             state_ff;
   vssl_pkg::back_state_type             state_in;
   vssl_pkg::cmd_type                    cmd_ff;
   logic signed [MUL_W-1:0]              op_a;
   logic signed [MUL_W-1:0]              op_b;
   logic signed [PROD_W-1:0]             prod_in;
   logic signed [PROD_W-1:0]             prod_ff;
   logic [vssl_pkg::SPEED_W-1:0]         mn_ff;
   logic [vssl_pkg::SPEED_W-1:0]         mx_ff;
   logic [vssl_pkg::SPEED_W-1:0]         mx_cur;
   logic                                 neg_ff;
   logic signed [15:0]                   target_ff;
   logic                                 brake_on_ff;
   logic                                 brake_big_ff;
   logic signed [15:0]                   prev_ff;
   logic signed [15:0]                   prev_in;
   logic                                 rsp_valid_ff;
   logic                                 rsp_valid_in;
   logic [vssl_pkg::RSP_DATA_W-1:0]      rsp_data_ff;
   logic                                 fin_fire;

   logic [PROD_W-1:0]                    blend_sum;
   logic [vssl_pkg::SPEED_W-1:0]         blend_res;
   logic [19:0]                          ts_sum;
   logic [14:0]                          t_y;
   logic [vssl_pkg::PROB_W-1:0]          t_val;
   logic [PROD_W-1:0]                    num_abs;
   logic [23:0]                          q_sum;
   logic [18:0]                          q_y;
   logic [17:0]                          q_ext;
   logic signed [17:0]                   target_wide;
   logic signed [15:0]                   target_cur;
   logic signed [16:0]                   d_val;
   logic [16:0]                          d_abs;
   logic signed [20:0]                   ten_t;
   logic signed [20:0]                   nine_p;
   logic [21:0]                          br_sum;
   logic [13:0]                          br_y;
   logic [11:0]                          brake_b;
   logic [vssl_pkg::BRAKE_W-1:0]         brake_val;
   logic signed [16:0]                   set_wide;
   logic [vssl_pkg::SPEED_W-1:0]         set_val;
   logic signed [16:0]                   diff_raw;
   logic signed [16:0]                   diff_clamped;
   logic signed [17:0]                   prev_sum;

   assign blend_sum = prod_ff + PROD_W'(2048);
   assign blend_res = min_speed + blend_sum[24:12];
   assign ts_sum    = prod_ff[19:0] + 20'd80;
   assign t_y       = ts_sum[19:5];
   assign t_val     = prod_ff[30:18];
   assign mx_cur    = (cmd_ff.a < STRAIGHT_ZONE) ? blend_res : mx_ff;
   assign num_abs   = prod_ff[PROD_W-1] ? (-prod_ff) : prod_ff;
   assign q_sum     = num_abs[23:0] + 24'd240;
   assign q_y       = q_sum[23:5];
   assign q_ext     = {2'b00, prod_ff[39:24]};

   assign target_wide = $signed({5'b00000, mx_ff}) + (neg_ff ? -$signed(q_ext) : $signed(q_ext));
   always_comb begin
      if (target_wide > SAT_HI) begin
         target_cur = 16'sh7fff;
      end else if (target_wide < SAT_LO) begin
         target_cur = -16'sh8000;
      end else begin
         target_cur = target_wide[15:0];
      end
   end

   assign d_val  = {prev_ff[15], prev_ff} - {target_cur[15], target_cur};
   assign d_abs  = d_val[16] ? (-d_val) : d_val;
   assign ten_t  = ({{5{target_cur[15]}}, target_cur} <<< 3)
                   + ({{5{target_cur[15]}}, target_cur} <<< 1);
   assign nine_p = ({{5{prev_ff[15]}}, prev_ff} <<< 3) + {{5{prev_ff[15]}}, prev_ff};

   assign br_sum  = prod_ff[21:0] + 22'd640;
   assign br_y    = br_sum[21:8];
   assign brake_b = prod_ff[29:18];

   always_comb begin
      if (!brake_on_ff) begin
         brake_val = '0;
      end else if (brake_big_ff || (brake_b > 12'(BRAKE_MAX))) begin
         brake_val = BRAKE_MAX;
      end else begin
         brake_val = brake_b[vssl_pkg::BRAKE_W-1:0];
      end
   end

   assign set_wide = {target_ff[15], target_ff} - $signed({6'b000000, brake_val});
   always_comb begin
      if (set_wide < 17'sd0) begin
         set_val = '0;
      end else if (set_wide > 17'sd8191) begin
         set_val = 13'd8191;
      end else begin
         set_val = set_wide[vssl_pkg::SPEED_W-1:0];
      end
   end

   assign diff_raw = {target_ff[15], target_ff} - {prev_ff[15], prev_ff};
   always_comb begin
      if (diff_raw > STEP_UP) begin
         diff_clamped = STEP_UP;
      end else if (diff_raw < STEP_DOWN) begin
         diff_clamped = STEP_DOWN;
      end else begin
         diff_clamped = diff_raw;
      end
   end

   assign prev_sum = {{2{prev_ff[15]}}, prev_ff} + {diff_clamped[16], diff_clamped};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         vssl_pkg::ST_IDLE: begin
            if (!queue_status.empty) begin
               state_in = vssl_pkg::ST_MN;
            end
         end
         vssl_pkg::ST_MN:  state_in = vssl_pkg::ST_MX;
         vssl_pkg::ST_MX:  state_in = vssl_pkg::ST_TS;
         vssl_pkg::ST_TS:  state_in = vssl_pkg::ST_TD;
         vssl_pkg::ST_TD:  state_in = vssl_pkg::ST_DR;
         vssl_pkg::ST_DR:  state_in = vssl_pkg::ST_NUM;
         vssl_pkg::ST_NUM: state_in = vssl_pkg::ST_QT;
         vssl_pkg::ST_QT:  state_in = vssl_pkg::ST_TGT;
         vssl_pkg::ST_TGT: state_in = vssl_pkg::ST_BR;
         vssl_pkg::ST_BR:  state_in = vssl_pkg::ST_FIN;
         vssl_pkg::ST_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = vssl_pkg::ST_IDLE;
            end
         end
         default: state_in = vssl_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      pop      = 1'b0;
      fin_fire = 1'b0;
      op_a     = '0;
      op_b     = '0;
      unique case (state_ff)
         vssl_pkg::ST_IDLE: begin
            pop = !queue_status.empty;
         end
         vssl_pkg::ST_MN: begin
            op_a = MUL_W'(cmd_ff.mn_b) - MUL_W'(min_speed);
            op_b = MUL_W'(cmd_ff.p);
         end
         vssl_pkg::ST_MX: begin
            op_a = MUL_W'(cmd_ff.mx_b) - MUL_W'(min_speed);
            op_b = MUL_W'(cmd_ff.mx_w);
         end
         vssl_pkg::ST_TS: begin
            op_a = MUL_W'(cmd_ff.c);
            op_b = MUL_W'(STRAIGHT_ZONE) - MUL_W'(cmd_ff.a);
         end
         vssl_pkg::ST_TD: begin
            op_a = MUL_W'(t_y);
            op_b = MUL_W'(RECIP_5);
         end
         vssl_pkg::ST_DR: begin
            op_a = MUL_W'(mx_ff) - MUL_W'(min_speed);
            op_b = MUL_W'(vssl_pkg::Q12_ONE) - MUL_W'(t_val);
         end
         vssl_pkg::ST_NUM: begin
            op_a = MUL_W'(mn_ff) - MUL_W'(mx_cur);
            op_b = MUL_W'(cmd_ff.a);
         end
         vssl_pkg::ST_QT: begin
            op_a = MUL_W'(q_y);
            op_b = MUL_W'(RECIP_15);
         end
         vssl_pkg::ST_TGT: begin
            op_a = MUL_W'(d_abs[10:0]);
            op_b = MUL_W'(d_abs[10:0]);
         end
         vssl_pkg::ST_BR: begin
            op_a = MUL_W'(br_y);
            op_b = MUL_W'(RECIP_5);
         end
         vssl_pkg::ST_FIN: begin
            fin_fire = !rsp_valid_ff || rsp_tready;
         end
         default: begin
            pop = 1'b0;
         end
      endcase
   end

   assign prod_in = op_a * op_b;

   always_comb begin
      prev_in      = prev_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (fin_fire) begin
         rsp_valid_in = 1'b1;
         if (prev_sum > SAT_HI) begin
            prev_in = 16'sh7fff;
         end else if (prev_sum < SAT_LO) begin
            prev_in = -16'sh8000;
         end else begin
            prev_in = prev_sum[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vssl_pkg::ST_IDLE;
         prev_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prev_ff      <= prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cmd_ff <= queue_status.head;
      end
      if ((state_ff != vssl_pkg::ST_IDLE) && (state_ff != vssl_pkg::ST_FIN)) begin
         prod_ff <= prod_in;
      end
      case (state_ff)
         vssl_pkg::ST_MX: begin
            mn_ff <= blend_res;
         end
         vssl_pkg::ST_TS: begin
            mx_ff <= cmd_ff.mx_same ? mn_ff : blend_res;
         end
         vssl_pkg::ST_NUM: begin
            mx_ff <= mx_cur;
         end
         vssl_pkg::ST_QT: begin
            neg_ff <= prod_ff[PROD_W-1];
         end
         vssl_pkg::ST_TGT: begin
            target_ff    <= target_cur;
            brake_on_ff  <= ten_t < nine_p;
            brake_big_ff <= d_abs > 17'd2047;
         end
         default: begin
         end
      endcase
      if (fin_fire) begin
         rsp_data_ff <= {prev_in, brake_val, set_val};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== sv/vehicle_speed_setpoint_limiter.sv =====
// Speed set-point limiter: turns one frame's lane, action and steering data into a set speed.
//
// Requests arrive on the req_ stream channel, one transaction per camera frame; results
// leave on the rsp_ stream channel, one transaction per request, in order. The csr_ port
// holds the lowest, curve and detection speeds at byte addresses 0, 4 and 8; the user must
// write it only while the block is idle, which the block itself does not enforce.
// The front end accepts a request, updates the detection countdown and queues the chosen
// blend operands in a two-entry queue. Each back-end transaction takes nine steps through
// one shared 22 x 22 bit multiplier, each followed by a product register, one step that
// forms the result, and an idle step that takes the next queue entry.
// Reset clears the slewed speed, the countdown, the queue and the result valid flag, and
// loads the register defaults; a request can be taken as soon as reset is released.
// When the receiver stalls, the result waits in the output register, the back end holds in
// its last step, the queue fills, and req_tready then stays low until the back end takes
// the next queue entry.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vehicle_speed_setpoint_limiter (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // Fields from bit 0 up: lane_probability, sign_absent, steer_angle, straight_slow,
   // straight_normal, curve_likelihood, countdown_load, countdown_value, zero fill.
   input  logic [vssl_pkg::REQ_DATA_W-1:0]   req_tdata,
   // Fields from bit 0 up: action.
   input  logic [vssl_pkg::ACTION_W-1:0]     req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // Fields from bit 0 up: set_speed, brake_amount, slewed_speed.
   output logic [vssl_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [vssl_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [vssl_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [vssl_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   vssl_pkg::csr_type                 csr_ff;
   vssl_pkg::csr_type                 csr_in;
   logic                              csr_write;
   logic [1:0]                        csr_index;
   vssl_pkg::queue_write_type         queue_write;
   vssl_pkg::queue_status_type        queue_status;
   logic                              back_pop;
   logic [vssl_pkg::COUNT_W-1:0]      countdown;
   logic                              cd_step;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[3:2];

   always_comb begin
      csr_in = csr_ff;
      if (csr_write) begin
         unique case (csr_index)
            vssl_pkg::REG_MIN_SPEED:       csr_in.min_speed       = csr_pwdata[12:0];
            vssl_pkg::REG_CURVE_SPEED:     csr_in.curve_speed     = csr_pwdata[12:0];
            vssl_pkg::REG_DETECTION_SPEED: csr_in.detection_speed = csr_pwdata[12:0];
            default:                       csr_in = csr_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         vssl_pkg::REG_MIN_SPEED:       csr_prdata = 32'(csr_ff.min_speed);
         vssl_pkg::REG_CURVE_SPEED:     csr_prdata = 32'(csr_ff.curve_speed);
         vssl_pkg::REG_DETECTION_SPEED: csr_prdata = 32'(csr_ff.detection_speed);
         default:                       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.min_speed       <= vssl_pkg::MIN_SPEED_RESET;
         csr_ff.curve_speed     <= vssl_pkg::CURVE_SPEED_RESET;
         csr_ff.detection_speed <= vssl_pkg::DETECTION_SPEED_RESET;
      end else begin
         csr_ff <= csr_in;
      end
   end

   vssl_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr         (csr_ff),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .queue_full  (queue_status.full),
      .queue_write (queue_write),
      .countdown   (countdown)
   );

   vssl_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .queue_write (queue_write),
      .pop         (back_pop),
      .status      (queue_status)
   );

   vssl_back u_back (
      .clock        (clock),
      .reset        (reset),
      .min_speed    (csr_ff.min_speed),
      .queue_status (queue_status),
      .pop          (back_pop),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata)
   );

   assign cd_step = queue_write.valid && !req_tdata[65] && (countdown != '0);

   `ASSERT_IMPLY(a_pop_needs_entry, clock, reset, back_pop, !queue_status.empty)
   `ASSERT_IMPLY(a_brake_capped, clock, reset, rsp_tvalid, rsp_tdata[23:13] <= 11'd1024)
   `ASSERT_NEXT(a_countdown_step, clock, reset, cd_step, countdown == $past(countdown) - 8'd1)

endmodule
